/* rtl/core/sts_pkg.sv */
// Shared types, codes and byte classifiers for the token scanner.
// No dependencies.
package sts_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;
  localparam int BUNDLE_TOKS     = 4;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [4:0] {
    K_END, K_IDENT, K_KEYWORD, K_INT, K_FLOAT, K_STRING, K_CHAR, K_SYMBOL,
    K_HASHPAREN, K_BINSEL, K_ASSIGN, K_COLON, K_RETURN, K_LPAREN, K_RPAREN,
    K_LBRACKET, K_RBRACKET, K_PERIOD, K_SEMI, K_VBAR, K_ERROR
  } tok_kind_t;

  typedef enum logic [2:0] {
    E_NONE, E_OPEN_STR, E_OPEN_SYM, E_BAD_SYM, E_BAD_CHAR, E_OPEN_CHAR
  } err_code_t;

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_IDENT_COLON, M_MINUS, M_NUM, M_NUM_DOT,
    M_FLOAT, M_STR, M_STR_Q, M_CHAR, M_HASH, M_SYM_STR, M_SYM_STR_Q,
    M_SYM_ID, M_SYM_BIN, M_COLON, M_BIN
  } scan_mode_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_bin(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "<" ||
           c == ">" || c == "=" || c == "~" || c == "&" || c == "@" ||
           c == "%" || c == "," || c == "?" || c == "!";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c == "^" || c == "(" || c == ")" || c == "[" || c == "]" ||
           c == "." || c == ";" || c == "|";
  endfunction

  function automatic tok_kind_t punct_kind(logic [7:0] c);
    tok_kind_t k;
    unique case (c)
      "^":     k = K_RETURN;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACKET;
      "]":     k = K_RBRACKET;
      ".":     k = K_PERIOD;
      ";":     k = K_SEMI;
      default: k = K_VBAR;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/sts_byte_if.sv */
// Byte channel: valid/ready plus one source byte.
// No dependencies.
interface sts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

/* rtl/core/sts_tok_if.sv */
// Token channel: valid/ready plus one token record.
// No dependencies.
interface sts_tok_if #(
  parameter int OB = 20,
  parameter int LB = 16,
  parameter int NB = 16
);
  logic          valid;
  logic          ready;
  logic [4:0]    token_kind;
  logic [2:0]    error_code;
  logic [OB-1:0] start_offset;
  logic [LB-1:0] token_length;
  logic [NB-1:0] line_number;
  logic          last_of_run;
  modport source (output valid, output token_kind, output error_code,
                  output start_offset, output token_length, output line_number,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_code,
                input start_offset, input token_length, input line_number,
                input last_of_run, output ready);
endinterface

/* rtl/core/sts_front.sv */
// Front end: accepts source bytes, runs the scan state and packs the
// tokens each byte finishes into one bundle. Uses sts_pkg, sts_byte_if.
module sts_front #(
  parameter int OB = 20,
  parameter int LB = 16,
  parameter int NB = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  sts_byte_if.sink                      src,
  input  logic                          full,
  output logic                          push,
  output logic [4*(8+OB+LB+NB)+2:0]     bundle
);
  import sts_pkg::*;

  typedef struct packed {
    logic [4:0]    kind;
    logic [2:0]    err;
    logic [OB-1:0] start;
    logic [LB-1:0] len;
    logic [NB-1:0] line;
  } tok_t;

  typedef struct packed {
    scan_mode_t    mode;
    logic [OB-1:0] tstart;
    logic [NB-1:0] tline;
    logic [LB-1:0] len;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic       rescan;
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } step_t;

  st_t           st, st_next;
  logic [OB-1:0] off, off_next;
  logic [NB-1:0] cl, cl_next;
  tok_t          toks [BUNDLE_TOKS];
  logic [2:0]    nres;

  function automatic tok_t mk(tok_kind_t k, err_code_t e, logic [OB-1:0] s,
                              logic [LB-1:0] l, logic [NB-1:0] ln);
    tok_t t;
    t.kind = k; t.err = e; t.start = s; t.len = l; t.line = ln;
    return t;
  endfunction

  function automatic logic [LB-1:0] inc(logic [LB-1:0] v);
    return (v != '1) ? v + 1'b1 : v;
  endfunction

  function automatic step_t scan(st_t s, logic [7:0] c, logic [OB-1:0] o,
                                 logic [NB-1:0] ln);
    step_t         r;
    logic [OB-1:0] prev;
    logic [LB-1:0] g;
    r = '0;
    r.st = s;
    prev = o - 1'b1;
    g = inc(s.len);
    unique case (s.mode)
      M_COMMENT: begin
        if (c == "\"") r.st.mode = M_IDLE;
        else if (c == 8'h00) begin r.st.mode = M_IDLE; r.rescan = 1'b1; end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_num(c)) r.st.len = g;
        else if (c == ":") r.st.mode = M_IDENT_COLON;
        else begin
          r.t0 = mk(K_IDENT, E_NONE, s.tstart, s.len, s.tline); r.n = 2'd1;
          r.st.mode = M_IDLE; r.rescan = 1'b1;
        end
      end
      M_IDENT_COLON: begin
        r.st.mode = M_IDLE;
        if (c == "=") begin
          r.t0 = mk(K_IDENT, E_NONE, s.tstart, s.len, s.tline);
          r.t1 = mk(K_ASSIGN, E_NONE, prev, LB'(2), ln); r.n = 2'd2;
        end else begin
          r.t0 = mk(K_KEYWORD, E_NONE, s.tstart, g, s.tline); r.n = 2'd1;
          r.rescan = 1'b1;
        end
      end
      M_MINUS, M_BIN: begin
        if (is_num(c) && s.mode == M_MINUS) begin
          r.st.len = g; r.st.mode = M_NUM;
        end else begin
          r.st.mode = M_IDLE; r.n = 2'd1;
          if (is_bin(c)) r.t0 = mk(K_BINSEL, E_NONE, s.tstart, g, s.tline);
          else begin
            r.t0 = mk(K_BINSEL, E_NONE, s.tstart, s.len, s.tline);
            r.rescan = 1'b1;
          end
        end
      end
      M_NUM, M_FLOAT: begin
        if (is_num(c)) r.st.len = g;
        else if (c == "." && s.mode == M_NUM) r.st.mode = M_NUM_DOT;
        else begin
          r.t0 = mk((s.mode == M_NUM) ? K_INT : K_FLOAT, E_NONE, s.tstart, s.len,
                    s.tline);
          r.n = 2'd1; r.st.mode = M_IDLE; r.rescan = 1'b1;
        end
      end
      M_NUM_DOT: begin
        if (is_num(c)) begin r.st.len = inc(g); r.st.mode = M_FLOAT; end
        else begin
          r.t0 = mk(K_INT, E_NONE, s.tstart, s.len, s.tline);
          r.t1 = mk(K_PERIOD, E_NONE, prev, LB'(1), ln);
          r.n = 2'd2; r.st.mode = M_IDLE; r.rescan = 1'b1;
        end
      end
      M_STR, M_SYM_STR: begin
        if (c == 8'h00) begin
          r.t0 = mk(K_ERROR, (s.mode == M_STR) ? E_OPEN_STR : E_OPEN_SYM, s.tstart,
                    '0, s.tline);
          r.n = 2'd1; r.st.mode = M_IDLE; r.rescan = 1'b1;
        end else begin
          r.st.len = g;
          if (c == "'") r.st.mode = (s.mode == M_STR) ? M_STR_Q : M_SYM_STR_Q;
        end
      end
      M_STR_Q, M_SYM_STR_Q: begin
        if (c == "'") begin
          r.st.len = g; r.st.mode = (s.mode == M_STR_Q) ? M_STR : M_SYM_STR;
        end else begin
          r.t0 = mk((s.mode == M_STR_Q) ? K_STRING : K_SYMBOL, E_NONE, s.tstart,
                    s.len, s.tline);
          r.n = 2'd1; r.st.mode = M_IDLE; r.rescan = 1'b1;
        end
      end
      M_CHAR: begin
        r.n = 2'd1; r.st.mode = M_IDLE;
        if (c == 8'h00) begin
          r.t0 = mk(K_ERROR, E_OPEN_CHAR, s.tstart, '0, s.tline); r.rescan = 1'b1;
        end else r.t0 = mk(K_CHAR, E_NONE, s.tstart, g, s.tline);
      end
      M_HASH: begin
        if (c == "(") begin
          r.t0 = mk(K_HASHPAREN, E_NONE, s.tstart, LB'(2), s.tline);
          r.n = 2'd1; r.st.mode = M_IDLE;
        end else if (c == "'") begin r.st.len = g; r.st.mode = M_SYM_STR; end
        else if (is_alpha(c)) begin r.st.len = g; r.st.mode = M_SYM_ID; end
        else if (is_bin(c)) begin r.st.len = g; r.st.mode = M_SYM_BIN; end
        else begin
          r.t0 = mk(K_ERROR, E_BAD_SYM, s.tstart, '0, s.tline);
          r.n = 2'd1; r.st.mode = M_IDLE; r.rescan = 1'b1;
        end
      end
      M_SYM_ID: begin
        if (is_alpha(c) || is_num(c) || c == ":") r.st.len = g;
        else begin
          r.t0 = mk(K_SYMBOL, E_NONE, s.tstart, s.len, s.tline);
          r.n = 2'd1; r.st.mode = M_IDLE; r.rescan = 1'b1;
        end
      end
      M_SYM_BIN: begin
        r.n = 2'd1; r.st.mode = M_IDLE;
        if (is_bin(c)) r.t0 = mk(K_SYMBOL, E_NONE, s.tstart, g, s.tline);
        else begin
          r.t0 = mk(K_SYMBOL, E_NONE, s.tstart, s.len, s.tline); r.rescan = 1'b1;
        end
      end
      M_COLON: begin
        r.n = 2'd1; r.st.mode = M_IDLE;
        if (c == "=") r.t0 = mk(K_ASSIGN, E_NONE, s.tstart, LB'(2), s.tline);
        else begin
          r.t0 = mk(K_COLON, E_NONE, s.tstart, LB'(1), s.tline); r.rescan = 1'b1;
        end
      end
      default: begin
        r.st.mode = M_IDLE;
        priority if (is_blank(c)) r.n = 2'd0;
        else if (c == "\"") r.st.mode = M_COMMENT;
        else if (c == 8'h00) begin
          r.t0 = mk(K_END, E_NONE, o, '0, ln); r.n = 2'd1;
        end else if (is_alpha(c) || is_num(c) || c == "-" || c == "'" ||
                     c == "$" || c == "#" || c == ":" ||
                     (is_bin(c) && !is_punct(c))) begin
          r.st.tstart = o; r.st.tline = ln; r.st.len = LB'(1);
          priority if (is_alpha(c)) r.st.mode = M_IDENT;
          else if (is_num(c)) r.st.mode = M_NUM;
          else if (c == "-") r.st.mode = M_MINUS;
          else if (c == "'") r.st.mode = M_STR;
          else if (c == "$") r.st.mode = M_CHAR;
          else if (c == "#") r.st.mode = M_HASH;
          else if (c == ":") r.st.mode = M_COLON;
          else r.st.mode = M_BIN;
        end else if (is_punct(c)) begin
          r.t0 = mk(punct_kind(c), E_NONE, o, LB'(1), ln); r.n = 2'd1;
        end else begin
          r.t0 = mk(K_ERROR, E_BAD_CHAR, o, '0, ln); r.n = 2'd1;
        end
      end
    endcase
    return r;
  endfunction

  always_comb begin
    step_t r;
    st_t   s;
    logic  go;
    s = st;
    go = 1'b1;
    nres = '0;
    r = '0;
    for (int i = 0; i < BUNDLE_TOKS; i++) toks[i] = '0;
    for (int i = 0; i < 3; i++) begin
      if (go) begin
        r = scan(s, src.ch, off, cl);
        s = r.st;
        if (r.n != 2'd0) begin toks[nres[1:0]] = r.t0; nres = nres + 3'd1; end
        if (r.n == 2'd2) begin toks[nres[1:0]] = r.t1; nres = nres + 3'd1; end
        go = r.rescan;
      end
    end
    st_next = s;
    if (src.ch == 8'h00) begin
      st_next.mode = M_IDLE;
      off_next = '0;
      cl_next = NB'(1);
    end else begin
      off_next = off + 1'b1;
      cl_next = (src.ch == 8'h0a && cl != '1) ? cl + 1'b1 : cl;
    end
  end

  assign src.ready = !full;
  assign push = src.valid && !full && nres != 3'd0;
  assign bundle = {toks[3], toks[2], toks[1], toks[0], nres};

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode <= M_IDLE;
      st.tstart <= '0;
      st.tline <= NB'(1);
      st.len <= '0;
      off <= '0;
      cl <= NB'(1);
    end else if (src.valid && src.ready) begin
      st <= st_next;
      off <= off_next;
      cl <= cl_next;
    end
  end
endmodule

/* rtl/core/sts_queue.sv */
// Short bundle queue between front and back end.
// Uses sts_pkg.
module sts_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);
  import sts_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign empty = cnt == '0;
  assign full  = cnt == (AW+1)'(QUEUE_DEPTH);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

/* rtl/core/sts_back.sv */
// Back end: walks the tokens of the head bundle, one word per cycle while tok is ready,
// into a registered output. Uses sts_pkg, sts_tok_if.
module sts_back #(
  parameter int OB = 20,
  parameter int LB = 16,
  parameter int NB = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [4*(8+OB+LB+NB)+2:0] head,
  input  logic                      empty,
  output logic                      pop,
  sts_tok_if.source                 tok
);
  import sts_pkg::*;

  localparam int REC = 8 + OB + LB + NB;

  typedef struct packed {
    logic [4:0]    kind;
    logic [2:0]    err;
    logic [OB-1:0] start;
    logic [LB-1:0] len;
    logic [NB-1:0] line;
  } tok_t;

  logic       vld;
  tok_t       rec;
  logic       last;
  logic [1:0] idx;
  logic       load, is_last;

  assign is_last = {1'b0, idx} == head[2:0] - 3'd1;
  assign load    = !empty && (!vld || tok.ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= tok_t'(head[3 + REC*idx +: REC]);
      last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      idx <= '0;
    end else begin
      if (load) vld <= 1'b1;
      else if (tok.ready) vld <= 1'b0;
      if (load) idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  assign tok.valid        = vld;
  assign tok.token_kind   = rec.kind;
  assign tok.error_code   = rec.err;
  assign tok.start_offset = rec.start;
  assign tok.token_length = rec.len;
  assign tok.line_number  = rec.line;
  assign tok.last_of_run  = last;
endmodule

/* rtl/core/smalltalk_token_scanner.sv */
// Top level of the token scanner: front end, bundle queue, back end.
// Uses sts_pkg, sts_byte_if, sts_tok_if, sts_front, sts_queue, sts_back.
//
//   channel  dir  word
//   src      in   one source byte (ch), 0 ends the source
//   tok      out  one token record, last_of_run on the final one of a byte
//
// A byte is taken every cycle while the four-bundle queue has room; each
// byte's tokens (0 to 3) are scanned in that cycle and queued as a bundle.
// The back end sends one token per cycle from its output register while tok is ready, so
// bytes that make at most one token flow at one per cycle.
// A tok stall fills the queue and then holds src.ready low.
// Synchronous reset puts the scanner between tokens at offset 0, line 1.
module smalltalk_token_scanner #(
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = sts_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS   = sts_pkg::LINE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sts_byte_if.sink  src,
  sts_tok_if.source tok
);
  import sts_pkg::*;

  localparam int BW = 4 * (8 + OFFSET_BITS + LENGTH_BITS + LINE_BITS) + 3;

  logic          push, pop, empty, full;
  logic [BW-1:0] bundle, head;

  sts_front #(.OB(OFFSET_BITS), .LB(LENGTH_BITS), .NB(LINE_BITS)) u_front (
    .clk(clk), .rst(rst), .src(src), .full(full), .push(push), .bundle(bundle)
  );

  sts_queue #(.W(BW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(bundle), .pop(pop),
    .head(head), .empty(empty), .full(full)
  );

  sts_back #(.OB(OFFSET_BITS), .LB(LENGTH_BITS), .NB(LINE_BITS)) u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop), .tok(tok)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    tok.valid && tok.token_kind == K_END |-> tok.token_length == '0 && tok.last_of_run)
    else $error("malformed end token");
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    tok.valid && tok.token_kind != K_ERROR |-> tok.error_code == E_NONE)
    else $error("error code on non-error token");
`endif
endmodule

/* tb/sv/smalltalk_token_scanner_test.sv */
`timescale 1ns / 1ps
// Testbench for smalltalk_token_scanner: streams source bytes and checks each token word
// against an in-bench scanner model. Uses sts_pkg, sts_byte_if, sts_tok_if and the RTL.
module smalltalk_token_scanner_test;
  import sts_pkg::*;

  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [19:0] off;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } token_t;

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  sts_byte_if src_if ();
  sts_tok_if  tok_if ();

  smalltalk_token_scanner dut (.clk(clk), .rst(rst), .src(src_if), .tok(tok_if));

  // scanner model state
  scan_mode_t  mode;
  logic [7:0]  held_ch;
  logic [19:0] tok_start, byte_off;
  logic [15:0] cur_line, tok_line, run_len;
  token_t      step_toks[$];
  token_t      pending_toks[$];

  int  errors = 0;
  bit  tx_idle = 1, rx_idle = 1;
  int  hold_left = 0, stall_left = 0;

  function automatic bit letter_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit op_c(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "<", ">", "=", "~", "&", "@", "%", ",", "?", "!": return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void put_tok(tok_kind_t k, err_code_t e, logic [19:0] o,
                                  logic [15:0] l, logic [15:0] ln);
    token_t t;
    if (step_toks.size() >= 4) return;
    t = '{kind: k, err: e, off: o, len: l, line: ln, last: 1'b0};
    step_toks.push_back(t);
  endfunction

  function automatic void close_tok(tok_kind_t k, logic [15:0] l);
    put_tok(k, E_NONE, tok_start, l, tok_line);
    mode = M_IDLE;
  endfunction

  function automatic void fail_tok(err_code_t e);
    put_tok(K_ERROR, e, tok_start, 16'd0, tok_line);
    mode = M_IDLE;
  endfunction

  function automatic void bump();
    if (run_len != 16'hffff) run_len++;
  endfunction

  function automatic void open_tok(scan_mode_t m, logic [19:0] o);
    mode = m;
    tok_start = o;
    tok_line = cur_line;
    run_len = 16'd1;
  endfunction

  function automatic void scan_fresh(logic [7:0] c, logic [19:0] o);
    case (c)
      " ", 8'h09, 8'h0d, 8'h0a: return;
      "\"": begin mode = M_COMMENT; return; end
      8'h00: begin put_tok(K_END, E_NONE, o, 16'd0, cur_line); return; end
      "-": begin open_tok(M_MINUS, o); return; end
      "'": begin open_tok(M_STR, o); return; end
      "$": begin open_tok(M_CHAR, o); return; end
      "#": begin open_tok(M_HASH, o); return; end
      ":": begin open_tok(M_COLON, o); return; end
      "^": begin put_tok(K_RETURN, E_NONE, o, 16'd1, cur_line); return; end
      "(": begin put_tok(K_LPAREN, E_NONE, o, 16'd1, cur_line); return; end
      ")": begin put_tok(K_RPAREN, E_NONE, o, 16'd1, cur_line); return; end
      "[": begin put_tok(K_LBRACKET, E_NONE, o, 16'd1, cur_line); return; end
      "]": begin put_tok(K_RBRACKET, E_NONE, o, 16'd1, cur_line); return; end
      ".": begin put_tok(K_PERIOD, E_NONE, o, 16'd1, cur_line); return; end
      ";": begin put_tok(K_SEMI, E_NONE, o, 16'd1, cur_line); return; end
      "|": begin put_tok(K_VBAR, E_NONE, o, 16'd1, cur_line); return; end
      default: ;
    endcase
    if (letter_c(c)) open_tok(M_IDENT, o);
    else if (digit_c(c)) open_tok(M_NUM, o);
    else if (op_c(c)) open_tok(M_BIN, o);
    else put_tok(K_ERROR, E_BAD_CHAR, o, 16'd0, cur_line);
  endfunction

  // returns 1 when the byte must be scanned again
  function automatic bit scan_one(logic [7:0] c, logic [19:0] o);
    logic [19:0] prev;
    prev = o - 20'd1;
    case (mode)
      M_COMMENT: begin
        if (c == "\"") begin mode = M_IDLE; return 0; end
        if (c == 8'h00) begin mode = M_IDLE; return 1; end
        return 0;
      end
      M_IDENT: begin
        if (letter_c(c) || digit_c(c)) begin bump(); return 0; end
        if (c == ":") begin held_ch = c; mode = M_IDENT_COLON; return 0; end
        close_tok(K_IDENT, run_len); return 1;
      end
      M_IDENT_COLON: begin
        if (c == "=") begin
          close_tok(K_IDENT, run_len);
          put_tok(K_ASSIGN, E_NONE, prev, 16'd2, cur_line);
          return 0;
        end
        close_tok(K_KEYWORD, run_len != 16'hffff ? run_len + 16'd1 : run_len);
        return 1;
      end
      M_MINUS: begin
        if (digit_c(c)) begin bump(); mode = M_NUM; return 0; end
        if (op_c(c)) begin bump(); close_tok(K_BINSEL, run_len); return 0; end
        close_tok(K_BINSEL, run_len); return 1;
      end
      M_NUM: begin
        if (digit_c(c)) begin bump(); return 0; end
        if (c == ".") begin held_ch = c; mode = M_NUM_DOT; return 0; end
        close_tok(K_INT, run_len); return 1;
      end
      M_NUM_DOT: begin
        if (digit_c(c)) begin bump(); bump(); mode = M_FLOAT; return 0; end
        close_tok(K_INT, run_len);
        scan_fresh(held_ch, prev);
        return 1;
      end
      M_FLOAT: begin
        if (digit_c(c)) begin bump(); return 0; end
        close_tok(K_FLOAT, run_len); return 1;
      end
      M_STR, M_SYM_STR: begin
        if (c == 8'h00) begin
          fail_tok(mode == M_STR ? E_OPEN_STR : E_OPEN_SYM); return 1;
        end
        bump();
        if (c == "'") mode = (mode == M_STR) ? M_STR_Q : M_SYM_STR_Q;
        return 0;
      end
      M_STR_Q, M_SYM_STR_Q: begin
        if (c == "'") begin
          bump(); mode = (mode == M_STR_Q) ? M_STR : M_SYM_STR; return 0;
        end
        close_tok(mode == M_STR_Q ? K_STRING : K_SYMBOL, run_len); return 1;
      end
      M_CHAR: begin
        if (c == 8'h00) begin fail_tok(E_OPEN_CHAR); return 1; end
        bump(); close_tok(K_CHAR, run_len); return 0;
      end
      M_HASH: begin
        if (c == "(") begin close_tok(K_HASHPAREN, 16'd2); return 0; end
        if (c == "'") begin bump(); mode = M_SYM_STR; return 0; end
        if (letter_c(c)) begin bump(); mode = M_SYM_ID; return 0; end
        if (op_c(c)) begin bump(); mode = M_SYM_BIN; return 0; end
        fail_tok(E_BAD_SYM); return 1;
      end
      M_SYM_ID: begin
        if (letter_c(c) || digit_c(c) || c == ":") begin bump(); return 0; end
        close_tok(K_SYMBOL, run_len); return 1;
      end
      M_SYM_BIN: begin
        if (op_c(c)) begin bump(); close_tok(K_SYMBOL, run_len); return 0; end
        close_tok(K_SYMBOL, run_len); return 1;
      end
      M_COLON: begin
        if (c == "=") begin close_tok(K_ASSIGN, 16'd2); return 0; end
        close_tok(K_COLON, 16'd1); return 1;
      end
      M_BIN: begin
        if (op_c(c)) begin bump(); close_tok(K_BINSEL, run_len); return 0; end
        close_tok(K_BINSEL, run_len); return 1;
      end
      default: begin
        mode = M_IDLE;
        scan_fresh(c, o);
        return 0;
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] c);
    logic [19:0] o;
    o = byte_off;
    step_toks.delete();
    for (int g = 0; g < 3; g++)
      if (!scan_one(c, o)) break;
    if (c == 8'h00) begin
      mode = M_IDLE; byte_off = 20'd0; cur_line = 16'd1;
    end else begin
      byte_off = o + 20'd1;
      if (c == 8'h0a && cur_line != 16'hffff) cur_line++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) pending_toks.push_back(step_toks[i]);
  endfunction

  task automatic send_byte(logic [7:0] c);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk) src_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_if.valid <= 1'b1;
    src_if.ch <= c;
    forever begin
      @(posedge clk);
      if (src_if.ready) break;
    end
    predict_tokens(c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    @(negedge clk) src_if.valid <= 1'b0;
    while (pending_toks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receive side: check each word, then draw the next stall
  initial begin
    token_t want;
    tok_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tok_if.valid && tok_if.ready) begin
        if (pending_toks.size() == 0) begin
          errors++;
          $display("%0t unexpected token: expected none, actual kind %0d off %0d",
                   $time, tok_if.token_kind, tok_if.start_offset);
        end else begin
          want = pending_toks.pop_front();
          if (tok_if.token_kind !== want.kind) begin
            errors++;
            $display("%0t kind: expected %0d, actual %0d", $time, want.kind,
                     tok_if.token_kind);
          end
          if (tok_if.error_code !== want.err) begin
            errors++;
            $display("%0t error_code: expected %0d, actual %0d", $time, want.err,
                     tok_if.error_code);
          end
          if (tok_if.start_offset !== want.off) begin
            errors++;
            $display("%0t start_offset: expected %0d, actual %0d", $time, want.off,
                     tok_if.start_offset);
          end
          if (tok_if.token_length !== want.len) begin
            errors++;
            $display("%0t token_length: expected %0d, actual %0d", $time, want.len,
                     tok_if.token_length);
          end
          if (tok_if.line_number !== want.line) begin
            errors++;
            $display("%0t line_number: expected %0d, actual %0d", $time, want.line,
                     tok_if.line_number);
          end
          if (tok_if.last_of_run !== want.last) begin
            errors++;
            $display("%0t last_of_run: expected %0d, actual %0d", $time, want.last,
                     tok_if.last_of_run);
          end
        end
        stall_left = rx_idle ? $urandom_range(0, 3) : 0;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        tok_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        tok_if.ready <= 1'b0;
      end else begin
        tok_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_text("foo bar: x:=3 -5 - 12.5 3.x 'it''s' $a #( #'s''y' #k:w: #+ #+- ");
    send_text("#++ : := ^()[].;| + -> ~ a:b \"note\" \n# 5 #1 77.");
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(8'h01);
    send_text("\n\tq\r");
    send_byte(8'h00);
    send_text("'open");
    send_byte(8'h00);
    send_text("#'open");
    send_byte(8'h00);
    send_text("$");
    send_byte(8'h00);
    send_text("\"open comment");
    send_byte(8'h00);
    send_text("x: 4.");
    send_byte(8'h00);
    drain();
  endtask

  function automatic string pick(string p);
    int i;
    i = $urandom_range(0, p.len() - 1);
    return p.substr(i, i);
  endfunction

  function automatic string rand_fragment();
    string s;
    int n;
    n = $urandom_range(1, 4);
    case ($urandom_range(0, 13))
      0: begin s = "v"; repeat (n) s = {s, pick("a1Z_")}; end
      1: begin s = "at"; s = {s, ":"}; end
      2: s = $sformatf("%0d", $urandom_range(0, 9999));
      3: s = $sformatf("-%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
      4: begin s = "'"; repeat (n) s = {s, pick("a''b\"")}; s = {s, "'"}; end
      5: s = {"$", pick("a'$ \"(")};
      6: s = {"#", pick("(+a'"), pick("b:-'")};
      7: s = {pick("+-*/<>=~&@%,?!"), pick("+-=> ")};
      8: s = ":=";
      9: s = {":", pick(" =")};
      10: s = pick("^()[].;|");
      11: s = "\"cm\"";
      12: s = {"x:", pick(" =9")};
      default: s = $sformatf("%0d.", $urandom_range(0, 9));
    endcase
    return s;
  endfunction

  task automatic test_random();
    int sent;
    string s;
    sent = 0;
    while (sent < 100) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        s = rand_fragment();
        send_text(s);
        sent += s.len();
      end
      if ($urandom_range(0, 3) == 0) begin
        send_text(pick(" \n"));
        sent++;
      end
      if ($urandom_range(0, 39) == 0) begin
        send_byte(8'h00);
        sent++;
      end
      if ($urandom_range(0, 60) == 0) begin
        tx_idle = 0;
        rx_idle = !rx_idle;
      end else begin
        tx_idle = 1;
      end
    end
    rx_idle = 1;
    tx_idle = 1;
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_backpressure();
    hold_left = 200;
    tx_idle = 0;
    repeat (20) send_text("(.a ");
    send_byte(8'h00);
    tx_idle = 1;
    drain();
  endtask

  initial begin
    src_if.valid = 1'b0;
    src_if.ch = 8'h00;
    mode = M_IDLE;
    held_ch = 8'h00;
    tok_start = 20'd0;
    byte_off = 20'd0;
    cur_line = 16'd1;
    tok_line = 16'd1;
    run_len = 16'd0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
